// ===== rtl/spq_pkg.sv =====
// Package with the shared types, sizes and codes of the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int PRI_W       = 16;
    localparam int STAT_W      = 2;
    localparam int OCC_W       = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     cmd;
        logic signed [VAL_W-1:0]  value_in;
        logic signed [PRI_W-1:0]  priority_in;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value_out;
        logic signed [PRI_W-1:0]  priority_out;
        logic        [STAT_W-1:0] status;
        logic        [OCC_W-1:0]  occupancy;
    } t_out;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic signed [PRI_W-1:0]  prio;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue: holds an entry and shifts it toward or away from the head.
`default_nettype none
module spq_cell (
    input  wire                 i_clk,
    input  spq_pkg::t_cell_ctl  i_ctl,
    input  wire                 i_occ,
    input  wire                 i_prev_keep,
    input  spq_pkg::t_entry     i_new,
    input  spq_pkg::t_entry     i_prev,
    input  spq_pkg::t_entry     i_next,
    output spq_pkg::t_entry     o_entry,
    output logic                o_keep
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // An occupied slot whose priority is at least the new one stays in front of it.
    assign o_keep  = i_occ && (r_entry.prio >= i_new.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.insert) begin
            if (!o_keep) begin
                n_entry = i_prev_keep ? i_new : i_prev;
            end
        end else if (i_ctl.remove) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell row, entry count and result register.
`default_nettype none
// A bounded priority queue of QUEUE_DEPTH entries kept sorted in a row of cells, highest
// priority at the head; equal priorities leave in arrival order. Each beat is one insert or
// one remove and yields one result beat with a status, the occupancy and, for a remove, the
// removed entry. All cells compare their priority with the new one in parallel and shift
// by one place at once, so one beat is taken per cycle unless the result is stalled. A
// result is registered when its beat is accepted, and a new beat is taken whenever the
// result register is empty or being drained. Entries beyond the count are never read, so no
// clearing is done after reset.
module sorted_priority_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  spq_pkg::t_in     i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output spq_pkg::t_out    o_data
);
    import spq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;
    logic             accept;
    logic             is_full;
    logic             is_empty;
    t_cell_ctl        ctl;
    t_entry           new_entry;
    t_entry           cell_q [QUEUE_DEPTH];
    logic             keep   [QUEUE_DEPTH];

    assign o_ready   = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign is_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty  = (r_count == '0);
    assign new_entry = '{value: i_data.value_in, prio: i_data.priority_in};

    assign ctl = '{insert: accept && (i_data.cmd == CMD_INSERT) && !is_full,
                   remove: accept && (i_data.cmd == CMD_REMOVE) && !is_empty};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
        logic   occ;
        logic   prev_keep;
        t_entry prev_entry;
        t_entry next_entry;

        assign occ = (IDX < r_count);

        if (g == 0) begin : g_head
            assign prev_keep  = 1'b1;
            assign prev_entry = new_entry;
        end else begin : g_body
            assign prev_keep  = keep[g-1];
            assign prev_entry = cell_q[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_entry = cell_q[g];
        end else begin : g_inner
            assign next_entry = cell_q[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occ       (occ),
            .i_prev_keep (prev_keep),
            .i_new       (new_entry),
            .i_prev      (prev_entry),
            .i_next      (next_entry),
            .o_entry     (cell_q[g]),
            .o_keep      (keep[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ctl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.remove) begin
            n_count = r_count - CNT_W'(1);
        end

        n_out              = '0;
        n_out.occupancy    = OCC_W'(n_count);
        unique case (i_data.cmd)
            CMD_INSERT: begin
                n_out.status = is_full ? ST_FULL : ST_OK;
            end
            CMD_REMOVE: begin
                if (is_empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.status       = ST_OK;
                    n_out.value_out    = cell_q[0].value;
                    n_out.priority_out = cell_q[0].prio;
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire
